@@ hw/rtl/ism_pkg.sv @@
// Package: payload types and constants of the interval set block.
package ism_pkg;
    localparam int MaxIntervals = 16;
    localparam int TimeBits     = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_MATCH  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] start_time;
        logic [31:0] stop_time;
        logic [31:0] query_time;
    } t_in;

    typedef struct packed {
        logic [4:0]  entry_count;
        logic        inside_interval;
        logic [31:0] seconds_left;
        logic        exact_match;
        logic        table_overflow;
    } t_out;
endpackage

@@ hw/rtl/ism_cell.sv @@
// Cell: one stored interval; one link of the rotating chain used for insert and merge.
module ism_cell #(
    parameter int TIME_W = ism_pkg::TimeBits
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_in_vld,
    input  logic [TIME_W-1:0] i_in_s,
    input  logic [TIME_W-1:0] i_in_e,
    output logic              o_vld,
    output logic [TIME_W-1:0] o_s,
    output logic [TIME_W-1:0] o_e
);
    logic              r_vld;
    logic [TIME_W-1:0] r_s, r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s <= i_in_s;
            r_e <= i_in_e;
        end
    end

    assign o_vld = r_vld;
    assign o_s   = r_s;
    assign o_e   = r_e;
endmodule

@@ hw/rtl/interval_set_merge_insert.sv @@
// Sequence: an accepted beat is checked against every cell in SCAN; query, match and unknown
// commands, and an insert dropped on a full table, then go to DONE, while any other insert
// first walks the cells in FILL to reach a free one. The result is registered from DONE.
// One item at a time: the next beat is taken only once the previous result has gone into
// the output register, so a result still waiting there under a stall holds off the next beat.
// Reset (synchronous, active low) empties the table and drops a waiting result.
module interval_set_merge_insert #(
    parameter int MAX_INTERVALS = ism_pkg::MaxIntervals,
    parameter int TIME_BITS     = ism_pkg::TimeBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ism_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ism_pkg::t_out o_out_data
);
    import ism_pkg::*;

    localparam int N  = MAX_INTERVALS;
    localparam int CW = $clog2(N + 1);
    localparam int KW = $clog2(N);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FILL = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [KW-1:0]        r_k;
    logic [CW-1:0]        r_cnt;
    t_cmd                 r_cmd;
    logic [TIME_BITS-1:0] r_a, r_b, r_t;
    // merged interval grows while the chain rotates
    logic [TIME_BITS-1:0] r_ps, r_pe;
    logic                 r_merged, r_found, r_match, r_ovf;
    logic [TIME_BITS-1:0] r_bs, r_be;
    logic                 r_out_vld;
    t_out                 r_obuf;

    logic [N-1:0]         w_vld;
    logic [TIME_BITS-1:0] w_s [N];
    logic [TIME_BITS-1:0] w_e [N];
    logic                 w_load, w_hvld;
    logic [TIME_BITS-1:0] w_hs, w_he;
    logic [TIME_BITS-1:0] w_ia, w_ib, w_lo_in, w_hi_in;
    logic                 w_tv, w_ov, w_absorb, w_last, w_full, w_out_free;
    logic [TIME_BITS-1:0] w_ts, w_te;
    logic                 w_inside;
    logic [TIME_BITS-1:0] w_left;
    t_out                 w_res;

    assign w_ia    = TIME_BITS'(i_in_data.start_time);
    assign w_ib    = TIME_BITS'(i_in_data.stop_time);
    assign w_lo_in = (w_ib < w_ia) ? w_ib : w_ia;
    assign w_hi_in = (w_ib < w_ia) ? w_ia : w_ib;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_head
                ism_cell #(.TIME_W(TIME_BITS)) u_cell (
                    .i_clk, .i_rst_n, .i_load(w_load),
                    .i_in_vld(w_hvld), .i_in_s(w_hs), .i_in_e(w_he),
                    .o_vld(w_vld[g]), .o_s(w_s[g]), .o_e(w_e[g]));
            end else begin : g_body
                ism_cell #(.TIME_W(TIME_BITS)) u_cell (
                    .i_clk, .i_rst_n, .i_load(w_load),
                    .i_in_vld(w_vld[g-1]), .i_in_s(w_s[g-1]), .i_in_e(w_e[g-1]),
                    .o_vld(w_vld[g]), .o_s(w_s[g]), .o_e(w_e[g]));
            end
        end
    endgenerate

    // tail cell holds the entry examined this cycle; entries sit in any cell, unordered
    assign w_tv = w_vld[N-1];
    assign w_ts = w_s[N-1];
    assign w_te = w_e[N-1];

    assign w_ov       = (w_ts <= r_b) && (r_a <= w_te);
    assign w_absorb   = (r_state == ST_SCAN) && (r_cmd == CMD_INSERT) && w_tv && w_ov;
    assign w_last     = (r_k == KW'(N - 1));
    assign w_full     = !r_merged && !w_absorb && (r_cnt == CW'(N));
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_load     = (r_state == ST_SCAN) || (r_state == ST_FILL);

    // recirculate the tail; drop absorbed entries; drop the merged interval into a free cell
    always_comb begin
        w_hvld = w_tv;
        w_hs   = w_ts;
        w_he   = w_te;
        if (w_absorb) begin
            w_hvld = 1'b0;
        end else if (r_state == ST_FILL && !w_tv) begin
            w_hvld = 1'b1;
            w_hs   = r_ps;
            w_he   = r_pe;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN: if (w_last) begin
                n_state = (r_cmd == CMD_INSERT && !w_full) ? ST_FILL : ST_DONE;
            end
            ST_FILL: if (!w_tv) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_absorb) begin
                r_cnt <= r_cnt - CW'(1);
            end else if (r_state == ST_FILL && !w_tv) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                r_k      <= '0;
                r_cmd    <= t_cmd'(i_in_data.command);
                r_a      <= w_lo_in;
                r_b      <= w_hi_in;
                r_t      <= TIME_BITS'(i_in_data.query_time);
                r_ps     <= w_lo_in;
                r_pe     <= w_hi_in;
                r_merged <= 1'b0;
                r_found  <= 1'b0;
                r_match  <= 1'b0;
                r_ovf    <= 1'b0;
            end
            ST_SCAN: begin
                r_k <= r_k + KW'(1);
                if (w_tv) begin
                    unique case (r_cmd)
                        CMD_INSERT: if (w_ov) begin
                            r_merged <= 1'b1;
                            if (w_ts < r_ps) r_ps <= w_ts;
                            if (w_te > r_pe) r_pe <= w_te;
                        end
                        // stored intervals never touch, so the earliest stop is the first one
                        CMD_QUERY: if (r_t < w_te && (!r_found || w_te < r_be)) begin
                            r_found <= 1'b1;
                            r_bs    <= w_ts;
                            r_be    <= w_te;
                        end
                        CMD_MATCH: if (w_ts == r_a && w_te == r_b) r_match <= 1'b1;
                        default: ;
                    endcase
                end
                if (w_last && r_cmd == CMD_INSERT && w_full) r_ovf <= 1'b1;
            end
            ST_FILL: ;
            ST_DONE: if (w_out_free) r_obuf <= w_res;
            default: ;
        endcase
    end

    always_comb begin
        w_inside = r_found && (r_bs <= r_t);
        if (!r_found) begin
            w_left = '0;
        end else if (w_inside) begin
            w_left = r_be - r_t;
        end else begin
            w_left = r_bs - r_t;
        end
        w_res.entry_count     = 5'(r_cnt);
        w_res.inside_interval = w_inside;
        w_res.seconds_left    = 32'(w_left);
        w_res.exact_match     = r_match;
        w_res.table_overflow  = r_ovf;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_obuf;
endmodule

@@ hw/rtl/ism_checker.sv @@
// Checker: port-level properties of the interval set block, with bind.
module ism_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ism_pkg::t_out o_out_data
);
    import ism_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entry_count <= 5'(MaxIntervals))
        else $error("entry count beyond table");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while busy");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.exact_match && o_out_data.table_overflow))
        else $error("match and overflow together");
endmodule

bind interval_set_merge_insert ism_checker u_ism_checker (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall, .o_out_data);
